[rtl/core/aol_pkg.sv]
// Package for the audio overdub looper: sizes, codes and shared types.
// Used by the channel interfaces and by the looper core. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package aol_pkg;

  // Loop memory and sample geometry.
  localparam int LOOP_DEPTH = 1048576;
  localparam int ADDR_W     = $clog2(LOOP_DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int SAMPLE_W   = 24;

  // Wet/dry mix in Q1.16, where one is 1 << FRAC_W.
  localparam int FRAC_W  = 16;
  localparam int WET_W   = FRAC_W + 1;
  localparam logic [WET_W-1:0] WET_ONE = WET_W'(1 << FRAC_W);

  // Kind of an input transaction.
  typedef enum logic [1:0] {
    KIND_SAMPLE     = 2'd0,
    KIND_REC_PRESS  = 2'd1,
    KIND_REC_HOLD   = 2'd2,
    KIND_PLAY_PRESS = 2'd3
  } kind_t;

  // Sample path sequencer.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FINISH
  } aol_state_t;

  // Status flags reported with each output sample.
  typedef struct packed {
    logic recording;
    logic playing;
    logic length_set;
  } aol_stat_t;

endpackage : aol_pkg

`default_nettype wire

[rtl/core/aol_if.sv]
// Valid/ready channel interfaces for the looper's input and output transactions.
// Depends on aol_pkg for the sample width and the kind codes.
`timescale 1ns / 1ps
`default_nettype none

interface aol_in_if;
  import aol_pkg::*;

  logic                       valid;
  logic                       ready;
  kind_t                      kind;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, kind, sample, input ready);
  modport sink   (input valid, kind, sample, output ready);
endinterface : aol_in_if

interface aol_out_if;
  import aol_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       recording;
  logic                       playing;
  logic                       length_set;

  modport source (output valid, out_sample, recording, playing, length_set, input ready);
  modport sink   (input valid, out_sample, recording, playing, length_set, output ready);
endinterface : aol_out_if

`default_nettype wire

[rtl/core/audio_overdub_looper.sv]
// Audio overdub looper: one loop memory, read for each sample and written back while recording.
// A sample transaction passes through the lookup and finish states and its result is registered
// at the output; button transactions produce no output.
// The next sample is taken in the finish state, while the previous result is loaded.
// Reset (synchronous, rst_n low) clears control state, then a clearing pass writes zero to all
// LOOP_DEPTH entries, one a cycle, with the input held off; an armed record hold repeats it.
`timescale 1ns / 1ps
`default_nettype none

module audio_overdub_looper (
  input  wire                          clk,
  input  wire                          rst_n,
  aol_in_if.sink                       in_ch,
  aol_out_if.source                    out_ch,
  input  wire                          cfg_we,
  input  wire [aol_pkg::WET_W-1:0]     cfg_wdata
);
  import aol_pkg::*;

  localparam logic [CNT_W-1:0]  LEN_FULL  = CNT_W'(LOOP_DEPTH);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(LOOP_DEPTH - 1);
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + WET_W + 1;
  localparam int SUM_W  = PROD_W + 1;

  // Loop memory.
  logic signed [SAMPLE_W-1:0] loop_mem [LOOP_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic signed [SAMPLE_W-1:0] mem_wdata;

  // Sequencer and control state.
  aol_state_t         state_r, state_nxt;
  logic [ADDR_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]   len_r, len_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               first_r, first_nxt;
  logic               rec_r, rec_nxt;
  logic               play_r, play_nxt;
  logic               armed_r, armed_nxt;
  logic               clr_active_r, clr_active_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [WET_W-1:0]   mix_r;

  // Data path registers.
  logic signed [SAMPLE_W-1:0] smp_r;
  logic signed [PROD_W-1:0]   prod_r;
  aol_stat_t                  stat_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  aol_stat_t                  out_stat_r;

  // Handshake and sequencer outputs.
  logic in_ready;
  logic in_fire;
  logic is_smp;
  logic out_free;
  logic do_lookup;
  logic ld_out;

  // Lookup stage arithmetic.
  logic signed [DIFF_W-1:0]   avg_sum;
  logic signed [SAMPLE_W-1:0] avg;
  logic signed [SAMPLE_W-1:0] entry;
  logic [WET_W-1:0]           w_eff;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod_c;
  logic [CNT_W-1:0]           count_inc;
  logic [CNT_W-1:0]           pos_p1;
  logic [CNT_W-1:0]           pos_wrap;
  logic                       auto_fix;

  // Finish stage arithmetic.
  logic signed [SUM_W-1:0]    mix_sum;

  assign out_free = !out_valid_r || out_ch.ready;
  assign is_smp   = (in_ch.kind == KIND_SAMPLE);
  assign in_fire  = in_ch.valid && in_ready;

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && is_smp) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = (in_fire && is_smp) ? ST_LOOKUP : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer: outputs. A new transaction may enter while the previous result is loaded.
  always_comb begin
    in_ready  = 1'b0;
    do_lookup = 1'b0;
    ld_out    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = !clr_active_r;
      end
      ST_LOOKUP: begin
        do_lookup = 1'b1;
      end
      ST_FINISH: begin
        in_ready = !clr_active_r && out_free;
        ld_out   = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Lookup stage: overdub average, mix product and position advance.
  always_comb begin
    avg_sum   = DIFF_W'(rd_data_r) + DIFF_W'(smp_r);
    avg       = avg_sum[DIFF_W-1:1];
    entry     = rec_r ? avg : rd_data_r;
    // While recording the output is the entry itself, which a full wet share yields.
    w_eff     = (rec_r || (mix_r > WET_ONE)) ? WET_ONE : mix_r;
    diff      = DIFF_W'(entry) - DIFF_W'(smp_r);
    prod_c    = PROD_W'(diff) * PROD_W'($signed({1'b0, w_eff}));
    count_inc = count_r + CNT_W'(rec_r && first_r);
    auto_fix  = (count_inc == LEN_FULL);
    // The position never exceeds the length, so one subtract and a check for a
    // length of one cover the modulo.
    pos_p1    = CNT_W'(pos_r) + CNT_W'(1);
    pos_wrap  = (pos_p1 >= len_r) ? (pos_p1 - len_r) : pos_p1;
  end

  // Finish stage: floor of the Q1.16-weighted mix is the upper part of the sum.
  assign mix_sum = (SUM_W'(smp_r) <<< FRAC_W) + SUM_W'(prod_r);

  // Control state update for button transactions, lookups and the clearing pass.
  always_comb begin
    pos_nxt        = pos_r;
    len_nxt        = len_r;
    count_nxt      = count_r;
    first_nxt      = first_r;
    rec_nxt        = rec_r;
    play_nxt       = play_r;
    armed_nxt      = armed_r;
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;

    // Clearing pass walks the memory one entry a cycle.
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_LAST) clr_active_nxt = 1'b0;
    end

    if (in_fire) begin
      case (in_ch.kind)
        KIND_REC_PRESS: begin
          // Closing the first recording fixes the loop length.
          if (first_r && rec_r) begin
            first_nxt = 1'b0;
            len_nxt   = (count_r == '0) ? CNT_W'(1) : count_r;
            count_nxt = '0;
          end
          armed_nxt = 1'b1;
          play_nxt  = 1'b1;
          rec_nxt   = !rec_r;
        end
        KIND_REC_HOLD: begin
          if (armed_r) begin
            clr_active_nxt = 1'b1;
            clr_addr_nxt   = '0;
            pos_nxt        = '0;
            len_nxt        = LEN_FULL;
            count_nxt      = '0;
            first_nxt      = 1'b1;
            rec_nxt        = 1'b0;
            play_nxt       = 1'b0;
            armed_nxt      = 1'b0;
          end
        end
        KIND_PLAY_PRESS: begin
          if (rec_r || !first_r) begin
            play_nxt = !play_r;
            rec_nxt  = 1'b0;
          end
        end
        default: begin
          // Samples are handled in the lookup stage.
        end
      endcase
    end

    if (do_lookup) begin
      count_nxt = count_inc;
      if (auto_fix) begin
        first_nxt = 1'b0;
        len_nxt   = LEN_FULL;
        count_nxt = '0;
      end
      if (play_r) begin
        pos_nxt = (pos_wrap >= len_r) ? '0 : pos_wrap[ADDR_W-1:0];
      end
    end
  end

  // Memory write port: clearing pass or overdub write-back.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_r;
    mem_wdata = avg;
    if (clr_active_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (do_lookup && rec_r) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) loop_mem[mem_waddr] <= mem_wdata;
  end

  // Read port: the entry at the current position, registered.
  always_ff @(posedge clk) begin
    rd_data_r <= loop_mem[pos_r];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= '0;
      len_r        <= LEN_FULL;
      count_r      <= '0;
      first_r      <= 1'b1;
      rec_r        <= 1'b0;
      play_r       <= 1'b0;
      armed_r      <= 1'b0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      mix_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      len_r        <= len_nxt;
      count_r      <= count_nxt;
      first_r      <= first_nxt;
      rec_r        <= rec_nxt;
      play_r       <= play_nxt;
      armed_r      <= armed_nxt;
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
      if (cfg_we) mix_r <= cfg_wdata;
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Data path registers.
  always_ff @(posedge clk) begin
    if (in_fire && is_smp) smp_r <= in_ch.sample;
    if (do_lookup) begin
      prod_r            <= prod_c;
      stat_r.recording  <= rec_r;
      stat_r.playing    <= play_r;
      stat_r.length_set <= !(first_r && !auto_fix);
    end
    if (ld_out) begin
      out_sample_r <= mix_sum[FRAC_W+SAMPLE_W-1:FRAC_W];
      out_stat_r   <= stat_r;
    end
  end

  // Port drive.
  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_sample = out_sample_r;
  assign out_ch.recording  = out_stat_r.recording;
  assign out_ch.playing    = out_stat_r.playing;
  assign out_ch.length_set = out_stat_r.length_set;

  // No transaction is taken while the clearing pass owns the memory.
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_ch.ready)
    else $error("input accepted during clearing pass");

  // A write-back never competes with the clearing pass.
  a_lookup_not_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOKUP) |-> !clr_active_r)
    else $error("lookup overlaps clearing pass");

  // The position stays within the loop length, which the wrap logic relies on.
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(pos_r) <= len_r) && (len_r != '0))
    else $error("play position beyond loop length");

  // A new output only ever comes from the finish stage.
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("output raised outside finish stage");

endmodule : audio_overdub_looper

`default_nettype wire
